/* design/tgg_pkg.sv */
// Shared types and constants for the time-of-flight grid gesture classifier.
// No dependencies; every other file imports this package.
package tgg_pkg;

  // Grid size default and fixed field widths
  localparam int GRID_DIM_DEF = 8;
  localparam int EXT_W        = 5;   // box extent, holds up to 16
  localparam int AREA_W       = 7;
  localparam int PROD_W       = 12;  // aspect cross products
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;

  localparam logic [7:0] STATUS_VALID = 8'd5;
  localparam logic [3:0] TENTHS_UNIT  = 4'd10;

  // Pose codes
  localparam logic [1:0] POSE_NONE     = 2'd0;
  localparam logic [1:0] POSE_ROCK     = 2'd1;
  localparam logic [1:0] POSE_SCISSORS = 2'd2;
  localparam logic [1:0] POSE_PAPER    = 2'd3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LOW  = 3'd0,
    REG_WINDOW_HIGH = 3'd1,
    REG_MIN_ZONES   = 3'd2,
    REG_OPEN_SPLIT  = 3'd3,
    REG_ELONGATION  = 3'd4,
    REG_CONFIRM     = 3'd5,
    REG_DROP        = 3'd6
  } reg_index_t;

  // Input request
  typedef struct packed {
    logic signed [15:0] zone_distance;
    logic [7:0]         zone_status;
  } zone_t;

  // Result
  typedef struct packed {
    logic              hand_present;
    logic [AREA_W-1:0] zone_area;
    logic [3:0]        box_width;
    logic [3:0]        box_height;
    logic [1:0]        raw_pose;
    logic [1:0]        candidate_pose;
    logic [7:0]        streak_count;
    logic [1:0]        confirmed_pose;
    logic              confirm_now;
  } result_t;

  // Frame summary passed from the front to the back
  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [EXT_W-1:0]  width;
    logic [EXT_W-1:0]  height;
  } frame_t;

  // Configuration registers
  typedef struct packed {
    logic [12:0] window_low_mm;
    logic [12:0] window_high_mm;
    logic [6:0]  min_zones;
    logic [6:0]  open_area_split;
    logic [6:0]  elongation_tenths;
    logic [7:0]  confirm_frames;
    logic [7:0]  drop_frames;
  } cfg_t;

endpackage

/* design/tgg_front.sv */
// Front end: takes one zone per request, window test and bounding box tracking.
// Depends on tgg_pkg; pushes one frame summary as the last zone of a frame is accepted.
module tgg_front import tgg_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  zone_t  zone,
  input  cfg_t   cfg,
  output logic   push,
  output frame_t frame
);

  localparam int CW = $clog2(GRID_DIM);
  localparam logic [CW-1:0] LAST = CW'(GRID_DIM - 1);

  logic [CW-1:0]     row, pos;
  logic [AREA_W-1:0] vcount, vcount_next;
  logic [CW-1:0]     min_col, max_col, min_row, max_row;
  logic [CW-1:0]     min_col_next, max_col_next, min_row_next, max_row_next;
  logic [CW-1:0]     col;
  logic              hit, last_zone;

  assign col       = LAST - pos;
  assign last_zone = (row == LAST) && (pos == LAST);

  // Window and status test
  assign hit = (zone.zone_status == STATUS_VALID)
            && (zone.zone_distance >= $signed({3'b000, cfg.window_low_mm}))
            && (zone.zone_distance <= $signed({3'b000, cfg.window_high_mm}));

  // Box and count update for this zone
  always_comb begin
    vcount_next  = vcount;
    min_col_next = min_col;
    max_col_next = max_col;
    min_row_next = min_row;
    max_row_next = max_row;
    if (hit) begin
      if (vcount == '0) begin
        min_col_next = col;
        max_col_next = col;
        min_row_next = row;
        max_row_next = row;
      end else begin
        if (col < min_col) min_col_next = col;
        if (col > max_col) max_col_next = col;
        if (row < min_row) min_row_next = row;
        if (row > max_row) max_row_next = row;
      end
      if (vcount != {AREA_W{1'b1}}) vcount_next = vcount + 1'b1;
    end
  end

  // Summary of the finished frame
  assign push         = accept && last_zone;
  assign frame.area   = vcount_next;
  assign frame.width  = EXT_W'(max_col_next) - EXT_W'(min_col_next) + 1'b1;
  assign frame.height = EXT_W'(max_row_next) - EXT_W'(min_row_next) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      pos     <= '0;
      vcount  <= '0;
      min_col <= '0;
      max_col <= '0;
      min_row <= '0;
      max_row <= '0;
    end else if (accept) begin
      if (last_zone) begin
        row     <= '0;
        pos     <= '0;
        vcount  <= '0;
        min_col <= '0;
        max_col <= '0;
        min_row <= '0;
        max_row <= '0;
      end else begin
        if (pos == LAST) begin
          pos <= '0;
          row <= row + 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
        vcount  <= vcount_next;
        min_col <= min_col_next;
        max_col <= max_col_next;
        min_row <= min_row_next;
        max_row <= max_row_next;
      end
    end
  end

endmodule

/* design/tgg_queue.sv */
// Two-entry queue of frame summaries between front and back.
// Depends on tgg_pkg for frame_t.
module tgg_queue import tgg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output frame_t head
);

  frame_t     slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slot[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/tgg_back.sv */
// Back end: classifies a frame summary, tracks streaks, holds the result register.
// Depends on tgg_pkg.
module tgg_back import tgg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  frame_t  q_head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic [1:0]        candidate, confirmed;
  logic [7:0]        streak, empty_run;
  logic [1:0]        candidate_next, confirmed_next;
  logic [7:0]        streak_next, empty_run_next;
  logic [AREA_W-1:0] need;
  logic              present, now;
  logic [EXT_W-1:0]  big, little;
  logic [PROD_W-1:0] lhs, rhs;
  logic [1:0]        raw;
  result_t           res;

  assign pop = q_valid && (!out_valid || !out_stall);

  // Presence test, min_zones of zero acts as one
  assign need    = (cfg.min_zones == '0) ? AREA_W'(1) : cfg.min_zones;
  assign present = (q_head.area >= need);

  // Aspect by cross-multiplying in tenths
  always_comb begin
    big    = (q_head.width > q_head.height) ? q_head.width : q_head.height;
    little = (q_head.width < q_head.height) ? q_head.width : q_head.height;
    if (little == '0) little = EXT_W'(1);
    lhs = PROD_W'(big) * PROD_W'(TENTHS_UNIT);
    rhs = PROD_W'(cfg.elongation_tenths) * PROD_W'(little);
    if (lhs >= rhs) raw = POSE_SCISSORS;
    else if (q_head.area >= cfg.open_area_split) raw = POSE_PAPER;
    else raw = POSE_ROCK;
  end

  // Streak, candidate and empty run update
  always_comb begin
    candidate_next = candidate;
    confirmed_next = confirmed;
    streak_next    = streak;
    empty_run_next = empty_run;
    now            = 1'b0;
    if (present) begin
      empty_run_next = '0;
      if (raw == candidate) begin
        if (streak != 8'hFF) streak_next = streak + 1'b1;
      end else begin
        candidate_next = raw;
        streak_next    = 8'd1;
      end
      if (streak_next >= cfg.confirm_frames) begin
        confirmed_next = candidate_next;
        now            = 1'b1;
      end
    end else begin
      if (empty_run != 8'hFF) empty_run_next = empty_run + 1'b1;
      if (empty_run_next >= cfg.drop_frames) begin
        candidate_next = POSE_NONE;
        streak_next    = '0;
      end
    end
  end

  always_comb begin
    res.hand_present   = present;
    res.zone_area      = q_head.area;
    res.box_width      = present ? q_head.width[3:0] : 4'd0;
    res.box_height     = present ? q_head.height[3:0] : 4'd0;
    res.raw_pose       = present ? raw : POSE_NONE;
    res.candidate_pose = candidate_next;
    res.streak_count   = streak_next;
    res.confirmed_pose = confirmed_next;
    res.confirm_now    = now;
  end

  // Pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      candidate <= POSE_NONE;
      confirmed <= POSE_NONE;
      streak    <= '0;
      empty_run <= '0;
    end else if (pop) begin
      candidate <= candidate_next;
      confirmed <= confirmed_next;
      streak    <= streak_next;
      empty_run <= empty_run_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= res;
  end

endmodule

/* design/tof_grid_gesture_classifier_core.sv */
// Top level of the time-of-flight grid gesture classifier: config registers,
// front end, summary queue and back end. Depends on tgg_pkg and all tgg_ modules.
//
// Zones are taken one per clock cycle while in_stall is low, GRID_DIM*GRID_DIM
// requests per frame in sensor order; one result per frame passes through the
// summary queue and the output register. The front end does its window test and
// box update in the cycle a zone is accepted; the two-entry queue feeds the back
// end, which classifies a summary and updates the pose streak as it pops it.
// in_stall rises only when both queue entries hold frames that the output side
// has not drained, so with out_stall low the sustained rate is one zone a cycle.
// Configuration writes take effect at the next edge and belong in idle time.
module tof_grid_gesture_classifier_core import tgg_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  zone_t                 in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   accept, push, pop, q_full, q_valid;
  frame_t frame, q_head;

  assign accept   = in_valid && !in_stall;
  assign in_stall = q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_low_mm     <= 13'd200;
      cfg.window_high_mm    <= 13'd400;
      cfg.min_zones         <= 7'd4;
      cfg.open_area_split   <= 7'd22;
      cfg.elongation_tenths <= 7'd17;
      cfg.confirm_frames    <= 8'd5;
      cfg.drop_frames       <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LOW:  cfg.window_low_mm     <= cfg_data;
        REG_WINDOW_HIGH: cfg.window_high_mm    <= cfg_data;
        REG_MIN_ZONES:   cfg.min_zones         <= cfg_data[6:0];
        REG_OPEN_SPLIT:  cfg.open_area_split   <= cfg_data[6:0];
        REG_ELONGATION:  cfg.elongation_tenths <= cfg_data[6:0];
        REG_CONFIRM:     cfg.confirm_frames    <= cfg_data[7:0];
        REG_DROP:        cfg.drop_frames       <= cfg_data[7:0];
        default:         ;
      endcase
    end
  end

  tgg_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .zone   (in_data),
    .cfg    (cfg),
    .push   (push),
    .frame  (frame)
  );

  tgg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (frame),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tgg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An empty frame carries no box, no pose and no confirmation
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hand_present |->
      out_data.box_width == 4'd0 && out_data.raw_pose == POSE_NONE && !out_data.confirm_now)
    else $error("empty frame result carries box or pose");

  // A confirmation copies the candidate and needs a live streak
  a_confirm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.confirm_now |->
      out_data.confirmed_pose == out_data.candidate_pose && out_data.streak_count != 8'd0)
    else $error("confirmation does not match candidate");

  // A classified frame becomes the candidate
  a_candidate: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.raw_pose != POSE_NONE |->
      out_data.candidate_pose == out_data.raw_pose)
    else $error("candidate differs from this frame's pose");

  // A hand needs at least one counted zone
  a_area: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hand_present |-> out_data.zone_area != '0)
    else $error("hand reported with zero area");

endmodule
